/* design/longest_increasing_subsequence_top_defines.svh */
// Assertion macros for the longest increasing subsequence block.
// Used by the top level; depends on nothing else.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_TOP_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/lis_pkg.sv */
// Shared constants and types for the longest increasing subsequence block.
// Depends on nothing; every other design file but the defines header uses it.
`default_nettype none

package lis_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int VAL_W   = 16;
  localparam int LEN_W   = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } lis_state_t;

endpackage

`default_nettype wire

/* design/lis_in_if.sv */
// Input channel: one sequence element and its end marker per word.
// Depends on lis_pkg.
`default_nettype none

interface lis_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [lis_pkg::VAL_W-1:0]  value;
  logic                              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

/* design/lis_out_if.sv */
// Result channel: running length, end flag and overflow flag per word.
// Depends on lis_pkg.
`default_nettype none

interface lis_out_if;
  logic                       valid;
  logic                       ready;
  logic [lis_pkg::LEN_W-1:0]  length;
  logic                       done_res;
  logic                       overflow;

  modport source (output valid, output length, output done_res, output overflow, input ready);
  modport sink   (input valid, input length, input done_res, input overflow, output ready);
endinterface

`default_nettype wire

/* design/lis_ram.sv */
// Tail table storage: one write port, one read port with registered data.
// Depends on lis_pkg for depth and width.
`default_nettype none

module lis_ram (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [lis_pkg::ADDR_W-1:0]       waddr,
  input  wire logic signed [lis_pkg::VAL_W-1:0] wdata,
  input  wire logic                             re,
  input  wire logic [lis_pkg::ADDR_W-1:0]       raddr,
  output logic signed [lis_pkg::VAL_W-1:0]      rdata
);

  logic signed [lis_pkg::VAL_W-1:0] mem [lis_pkg::MAX_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/longest_increasing_subsequence_top.sv */
// Channel   Dir  Payload                       Handshake
// in_ch     in   value[15:0] signed, last      valid/ready
// out_ch    out  length[10:0], done_res, overflow  valid/ready
//
// Each word is taken in the idle state, then probes the tail table by binary
// search (no probe when it is empty), one probe at a time over the single
// read port of the table memory, and ends in the update state.
// Reset clears the count, the overflow flag and the control state; the table
// itself needs no clearing. A held result stalls only the update state.
// Depends on lis_pkg, lis_in_if, lis_out_if, lis_ram and the defines header.
`default_nettype none
`include "longest_increasing_subsequence_top_defines.svh"

module longest_increasing_subsequence_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lis_in_if.sink      in_ch,
  lis_out_if.source   out_ch
);

  lis_pkg::lis_state_t state_r, state_nxt;

  logic [lis_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [lis_pkg::CNT_W-1:0]        lo_r, lo_nxt;
  logic [lis_pkg::CNT_W-1:0]        hi_r, hi_nxt;
  logic signed [lis_pkg::VAL_W-1:0] v_r, v_nxt;
  logic                             last_r, last_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [lis_pkg::LEN_W-1:0]        out_len_r, out_len_nxt;
  logic                             out_done_r, out_done_nxt;
  logic                             out_ovf_r, out_ovf_nxt;

  logic                             accept;
  logic                             fire;
  logic                             less;
  logic [lis_pkg::CNT_W:0]          mid_sum;
  logic [lis_pkg::CNT_W-1:0]        mid_nxt;

  logic                             ram_we;
  logic [lis_pkg::ADDR_W-1:0]       ram_waddr;
  logic                             ram_re;
  logic signed [lis_pkg::VAL_W-1:0] ram_rdata;

  function automatic logic [lis_pkg::CNT_W-1:0] mid_nxt_from(
    input logic [lis_pkg::CNT_W-1:0] lo,
    input logic [lis_pkg::CNT_W-1:0] hi
  );
    logic [lis_pkg::CNT_W:0] s;
    s = {1'b0, lo} + {1'b0, hi};
    return s[lis_pkg::CNT_W:1];
  endfunction

  lis_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (v_r),
    .re    (ram_re),
    .raddr (mid_nxt[lis_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign accept = in_ch.valid && in_ch.ready;
  assign fire   = (state_r == lis_pkg::ST_UPDATE) && (!out_valid_r || out_ch.ready);
  assign less   = ram_rdata < v_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lis_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (cnt_r != '0) ? lis_pkg::ST_SEARCH : lis_pkg::ST_UPDATE;
        end
      end
      lis_pkg::ST_SEARCH: begin
        if (lo_nxt >= hi_nxt) begin
          state_nxt = lis_pkg::ST_UPDATE;
        end
      end
      lis_pkg::ST_UPDATE: begin
        if (fire) begin
          state_nxt = lis_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lis_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = (state_r == lis_pkg::ST_IDLE);
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = lo_r[lis_pkg::ADDR_W-1:0];
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_len_nxt   = out_len_r;
    out_done_nxt  = out_done_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      lis_pkg::ST_IDLE: begin
        if (accept) begin
          lo_nxt   = '0;
          hi_nxt   = cnt_r;
          v_nxt    = in_ch.value;
          last_nxt = in_ch.last;
        end
      end
      lis_pkg::ST_SEARCH: begin
        if (less) begin
          lo_nxt = mid_nxt_from(lo_r, hi_r) + lis_pkg::CNT_W'(1);
        end else begin
          hi_nxt = mid_nxt_from(lo_r, hi_r);
        end
      end
      lis_pkg::ST_UPDATE: begin
        if (fire) begin
          if (lo_r == cnt_r) begin
            if (cnt_r < lis_pkg::CNT_W'(lis_pkg::MAX_LEN)) begin
              ram_we    = 1'b1;
              ram_waddr = cnt_r[lis_pkg::ADDR_W-1:0];
              cnt_nxt   = cnt_r + lis_pkg::CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            ram_we = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_len_nxt   = lis_pkg::LEN_W'(cnt_nxt);
          out_done_nxt  = last_r;
          out_ovf_nxt   = ovf_nxt;
          if (last_r) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
          end
        end
      end
      default: begin
        lo_nxt = lo_r;
      end
    endcase
  end

  assign mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mid_nxt = mid_sum[lis_pkg::CNT_W:1];
  assign ram_re  = (state_nxt == lis_pkg::ST_SEARCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lis_pkg::ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    out_len_r  <= out_len_nxt;
    out_done_r <= out_done_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.length   = out_len_r;
  assign out_ch.done_res = out_done_r;
  assign out_ch.overflow = out_ovf_r;

  `LIS_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= lis_pkg::CNT_W'(lis_pkg::MAX_LEN), "count exceeds table depth")
  `LIS_ASSERT_NOW(a_search_open, clk, rst_n, state_r == lis_pkg::ST_SEARCH, (lo_r < hi_r) && (hi_r <= cnt_r), "search window is empty or beyond count")
  `LIS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r != lis_pkg::ST_IDLE, "block stayed idle after taking a word")
  `LIS_ASSERT_NEXT(a_fire_result, clk, rst_n, fire, out_valid_r && (out_done_r == $past(last_r)), "update did not present its result")

endmodule

`default_nettype wire
